/* rtl/pgf_pkg.sv */
// Shared widths, register codes and payload types of the pairwise gravity force block.
package pgf_pkg;

  localparam int POSITION_BITS  = 16;
  localparam int FORCE_BITS     = 32;
  localparam int GRAV_BITS      = 16;
  localparam int MASS_BITS      = 16;
  localparam int DIST_SQ_BITS   = 33;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = DIST_SQ_BITS;

  localparam int ABS_BITS       = POSITION_BITS;
  localparam int SQ_BITS        = 2 * POSITION_BITS + 1;
  localparam int ROOT_BITS      = POSITION_BITS + 1;
  localparam int GM_BITS        = GRAV_BITS + MASS_BITS;
  localparam int MASS_PROD_BITS = GRAV_BITS + 2 * MASS_BITS;
  localparam int PROD_BITS      = MASS_PROD_BITS + ABS_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GRAVITY     = 2'd0,
    REG_MIN_DIST_SQ = 2'd1,
    REG_MAX_DIST_SQ = 2'd2
  } pgf_cfg_reg_t;

  typedef struct packed {
    logic signed [POSITION_BITS-1:0] pos_a_x;
    logic signed [POSITION_BITS-1:0] pos_a_y;
    logic signed [POSITION_BITS-1:0] pos_b_x;
    logic signed [POSITION_BITS-1:0] pos_b_y;
    logic        [MASS_BITS-1:0]     mass_a;
    logic        [MASS_BITS-1:0]     mass_b;
  } pgf_item_t;

  typedef struct packed {
    logic signed [FORCE_BITS-1:0] force_x;
    logic signed [FORCE_BITS-1:0] force_y;
    logic                         saturated;
    logic                         coincident;
  } pgf_result_t;

endpackage

/* rtl/pgf_div_cell.sv */
// One restoring division step: a cell of the pipelined divider row.
module pgf_div_cell #(
  parameter int NUM_BITS  = 8,
  parameter int DEN_BITS  = 8,
  parameter int SIDE_BITS = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  logic [NUM_BITS-1:0]  num_in,
  input  logic [DEN_BITS-1:0]  rem_in,
  input  logic [DEN_BITS-1:0]  den_in,
  input  logic [SIDE_BITS-1:0] side_in,
  output logic                 valid_out,
  output logic [NUM_BITS-1:0]  num_out,
  output logic [DEN_BITS-1:0]  rem_out,
  output logic [DEN_BITS-1:0]  den_out,
  output logic [SIDE_BITS-1:0] side_out
);

  logic [DEN_BITS:0] trial;
  logic [DEN_BITS:0] diff;
  logic              take;

  // bring down the next dividend bit, subtract where it fits
  assign trial = {rem_in, num_in[NUM_BITS-1]};
  assign diff  = trial - {1'b0, den_in};
  assign take  = trial >= {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  // dividend bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    num_out  <= {num_in[NUM_BITS-2:0], take};
    rem_out  <= take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    den_out  <= den_in;
    side_out <= side_in;
  end

endmodule

/* rtl/pgf_sqrt_cell.sv */
// One digit-by-digit square root step: a cell of the pipelined root row.
module pgf_sqrt_cell #(
  parameter int ROOT_BITS = 8,
  parameter int SIDE_BITS = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid_in,
  input  logic [2*ROOT_BITS-1:0] rad_in,
  input  logic [ROOT_BITS+1:0]   rem_in,
  input  logic [ROOT_BITS-1:0]   root_in,
  input  logic [SIDE_BITS-1:0]   side_in,
  output logic                   valid_out,
  output logic [2*ROOT_BITS-1:0] rad_out,
  output logic [ROOT_BITS+1:0]   rem_out,
  output logic [ROOT_BITS-1:0]   root_out,
  output logic [SIDE_BITS-1:0]   side_out
);

  logic [ROOT_BITS+3:0] rem_sh;
  logic [ROOT_BITS+3:0] trial;
  logic [ROOT_BITS+3:0] diff;
  logic                 take;

  // two radicand bits per step against 4*root + 1
  assign rem_sh = {rem_in, rad_in[2*ROOT_BITS-1 -: 2]};
  assign trial  = {2'b00, root_in, 2'b01};
  assign diff   = rem_sh - trial;
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    rad_out  <= {rad_in[2*ROOT_BITS-3:0], 2'b00};
    rem_out  <= take ? diff[ROOT_BITS+1:0] : rem_sh[ROOT_BITS+1:0];
    root_out <= {root_in[ROOT_BITS-2:0], take};
    side_out <= side_in;
  end

endmodule

/* rtl/pairwise_gravity_force.sv */
// Top level of the pairwise gravity force pipeline.
// Computes the force on body A toward body B as G*ma*mb / clamp(|d|^2) along the
// unit vector of d = B - A, in fixed point (positions Q12.4, masses and G Q8.8,
// force Q16.16, saturated). One pair is taken in every clock cycle: busy stays
// low and start may be held high indefinitely. Each result appears on result
// with a one-cycle done strobe once its transfer has passed the registered
// stages and the rows of one-bit cells: the mass-over-distance divider (one
// cell per quotient bit), the square root row (one cell per root bit) and the
// two component dividers (one cell per product bit). The receiver cannot hold
// results off, so results are never stalled or dropped. Registers are written
// through cfg_we/cfg_index/cfg_data; the user must do so only while no pair is
// in flight, which the block itself does not enforce; index 3 is ignored.
module pairwise_gravity_force (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  pgf_pkg::pgf_item_t                  in_item,
  output logic                                done,
  output pgf_pkg::pgf_result_t                result,
  input  logic                                cfg_we,
  input  logic [pgf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pgf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import pgf_pkg::*;

  localparam int CMP_BITS = (SQ_BITS > DIST_SQ_BITS) ? SQ_BITS : DIST_SQ_BITS;
  localparam logic [PROD_BITS-1:0] POS_MAX =
    {{(PROD_BITS-FORCE_BITS+1){1'b0}}, {(FORCE_BITS-1){1'b1}}};
  localparam logic [PROD_BITS-1:0] NEG_MAX =
    {{(PROD_BITS-FORCE_BITS){1'b0}}, 1'b1, {(FORCE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [SQ_BITS-1:0]  sq;
    logic [ABS_BITS-1:0] ax;
    logic [ABS_BITS-1:0] ay;
    logic                nx;
    logic                ny;
    logic                coinc;
    logic                mzero;
    logic                inf;
  } fdiv_side_t;

  typedef struct packed {
    logic [MASS_PROD_BITS-1:0] f;
    logic [ABS_BITS-1:0]       ax;
    logic [ABS_BITS-1:0]       ay;
    logic                      nx;
    logic                      ny;
    logic                      coinc;
    logic                      mzero;
    logic                      inf;
  } root_side_t;

  typedef struct packed {
    logic nx;
    logic coinc;
    logic mzero;
    logic inf;
    logic axz;
    logic ayz;
  } xdiv_side_t;

  typedef struct packed {
    logic [FORCE_BITS-1:0] value;
    logic                  sat;
  } comp_t;

  localparam int FS_BITS = $bits(fdiv_side_t);
  localparam int RS_BITS = $bits(root_side_t);
  localparam int XS_BITS = $bits(xdiv_side_t);

  // Saturate one component; a zero d part or zero mass product gives zero.
  function automatic comp_t make_comp(input logic [PROD_BITS-1:0] q,
                                      input logic neg, input logic zero,
                                      input logic inf, input logic mzero);
    logic [PROD_BITS-1:0] qq;
    logic [PROD_BITS-1:0] nq;
    comp_t                c;
    qq      = inf ? {PROD_BITS{1'b1}} : q;
    nq      = -qq;
    c.value = '0;
    c.sat   = 1'b0;
    if (!(zero || mzero)) begin
      if (!neg) begin
        if (qq > POS_MAX) begin
          c.value = POS_MAX[FORCE_BITS-1:0];
          c.sat   = 1'b1;
        end else begin
          c.value = qq[FORCE_BITS-1:0];
        end
      end else begin
        if (qq > NEG_MAX) begin
          c.value = NEG_MAX[FORCE_BITS-1:0];
          c.sat   = 1'b1;
        end else begin
          c.value = nq[FORCE_BITS-1:0];
        end
      end
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- registers
  logic [GRAV_BITS-1:0]    gravity_constant;
  logic [DIST_SQ_BITS-1:0] min_distance_sq;
  logic [DIST_SQ_BITS-1:0] max_distance_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_constant <= GRAV_BITS'(256);
      min_distance_sq  <= DIST_SQ_BITS'(256);
      max_distance_sq  <= {DIST_SQ_BITS{1'b1}};
    end else if (cfg_we) begin
      case (pgf_cfg_reg_t'(cfg_index))
        REG_GRAVITY:     gravity_constant <= cfg_data[GRAV_BITS-1:0];
        REG_MIN_DIST_SQ: min_distance_sq  <= cfg_data[DIST_SQ_BITS-1:0];
        REG_MAX_DIST_SQ: max_distance_sq  <= cfg_data[DIST_SQ_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so every start is a transfer.
  assign busy = 1'b0;

  // ------------------------------------------------ stage 1: differences, G*ma
  logic [POSITION_BITS:0] dx;
  logic [POSITION_BITS:0] dy;
  logic [POSITION_BITS:0] dx_neg;
  logic [POSITION_BITS:0] dy_neg;

  assign dx = {in_item.pos_b_x[POSITION_BITS-1], in_item.pos_b_x}
            - {in_item.pos_a_x[POSITION_BITS-1], in_item.pos_a_x};
  assign dy = {in_item.pos_b_y[POSITION_BITS-1], in_item.pos_b_y}
            - {in_item.pos_a_y[POSITION_BITS-1], in_item.pos_a_y};
  assign dx_neg = -dx;
  assign dy_neg = -dy;

  logic                 s1_valid;
  logic [ABS_BITS-1:0]  s1_ax;
  logic [ABS_BITS-1:0]  s1_ay;
  logic                 s1_nx;
  logic                 s1_ny;
  logic [GM_BITS-1:0]   s1_gm;
  logic [MASS_BITS-1:0] s1_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_nx <= dx[POSITION_BITS];
    s1_ny <= dy[POSITION_BITS];
    s1_ax <= dx[POSITION_BITS] ? dx_neg[ABS_BITS-1:0] : dx[ABS_BITS-1:0];
    s1_ay <= dy[POSITION_BITS] ? dy_neg[ABS_BITS-1:0] : dy[ABS_BITS-1:0];
    s1_gm <= gravity_constant * in_item.mass_a;
    s1_mb <= in_item.mass_b;
  end

  // ---------------------------------------------- stage 2: squares, mass product
  logic                      s2_valid;
  logic [2*ABS_BITS-1:0]     s2_sx;
  logic [2*ABS_BITS-1:0]     s2_sy;
  logic [MASS_PROD_BITS-1:0] s2_m;
  logic [ABS_BITS-1:0]       s2_ax;
  logic [ABS_BITS-1:0]       s2_ay;
  logic                      s2_nx;
  logic                      s2_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_sx <= s1_ax * s1_ax;
    s2_sy <= s1_ay * s1_ay;
    s2_m  <= s1_gm * s1_mb;
    s2_ax <= s1_ax;
    s2_ay <= s1_ay;
    s2_nx <= s1_nx;
    s2_ny <= s1_ny;
  end

  // ------------------------------------------------ stage 3: squared distance
  logic                      s3_valid;
  logic [SQ_BITS-1:0]        s3_sq;
  logic [MASS_PROD_BITS-1:0] s3_m;
  logic [ABS_BITS-1:0]       s3_ax;
  logic [ABS_BITS-1:0]       s3_ay;
  logic                      s3_nx;
  logic                      s3_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_sq <= SQ_BITS'(s2_sx) + SQ_BITS'(s2_sy);
    s3_m  <= s2_m;
    s3_ax <= s2_ax;
    s3_ay <= s2_ay;
    s3_nx <= s2_nx;
    s3_ny <= s2_ny;
  end

  // ------------------------------------------------------- stage 4: clamping
  // Upper bound first, then the lower bound, so min above max yields min.
  logic [DIST_SQ_BITS-1:0] clamp_upper;
  logic [DIST_SQ_BITS-1:0] clamp_next;

  always_comb begin
    if (CMP_BITS'(s3_sq) > CMP_BITS'(max_distance_sq)) begin
      clamp_upper = max_distance_sq;
    end else begin
      clamp_upper = DIST_SQ_BITS'(s3_sq);
    end
    clamp_next = (clamp_upper < min_distance_sq) ? min_distance_sq : clamp_upper;
  end

  logic                      s4_valid;
  logic [DIST_SQ_BITS-1:0]   s4_clamp;
  logic [MASS_PROD_BITS-1:0] s4_m;
  fdiv_side_t                s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_clamp      <= clamp_next;
    s4_m          <= s3_m;
    s4_side.sq    <= s3_sq;
    s4_side.ax    <= s3_ax;
    s4_side.ay    <= s3_ay;
    s4_side.nx    <= s3_nx;
    s4_side.ny    <= s3_ny;
    s4_side.coinc <= (s3_sq == '0);
    s4_side.mzero <= (s3_m == '0);
    s4_side.inf   <= (clamp_next == '0) && (s3_m != '0);
  end

  // ------------------------------------- divider row: F = M / clamped distance
  logic                      fv    [0:MASS_PROD_BITS];
  logic [MASS_PROD_BITS-1:0] fn    [0:MASS_PROD_BITS];
  logic [DIST_SQ_BITS-1:0]   fr    [0:MASS_PROD_BITS];
  logic [DIST_SQ_BITS-1:0]   fd    [0:MASS_PROD_BITS];
  logic [FS_BITS-1:0]        fs    [0:MASS_PROD_BITS];

  assign fv[0] = s4_valid;
  assign fn[0] = s4_m;
  assign fr[0] = '0;
  assign fd[0] = s4_clamp;
  assign fs[0] = s4_side;

  for (genvar i = 0; i < MASS_PROD_BITS; i++) begin : g_fdiv
    pgf_div_cell #(
      .NUM_BITS (MASS_PROD_BITS),
      .DEN_BITS (DIST_SQ_BITS),
      .SIDE_BITS(FS_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (fv[i]),
      .num_in   (fn[i]),
      .rem_in   (fr[i]),
      .den_in   (fd[i]),
      .side_in  (fs[i]),
      .valid_out(fv[i+1]),
      .num_out  (fn[i+1]),
      .rem_out  (fr[i+1]),
      .den_out  (fd[i+1]),
      .side_out (fs[i+1])
    );
  end

  // ------------------------------------------- root row: L = floor(sqrt(sq))
  fdiv_side_t f_done;
  root_side_t r_first;

  assign f_done        = fdiv_side_t'(fs[MASS_PROD_BITS]);
  assign r_first.f     = fn[MASS_PROD_BITS];
  assign r_first.ax    = f_done.ax;
  assign r_first.ay    = f_done.ay;
  assign r_first.nx    = f_done.nx;
  assign r_first.ny    = f_done.ny;
  assign r_first.coinc = f_done.coinc;
  assign r_first.mzero = f_done.mzero;
  assign r_first.inf   = f_done.inf;

  logic                   rv [0:ROOT_BITS];
  logic [2*ROOT_BITS-1:0] rx [0:ROOT_BITS];
  logic [ROOT_BITS+1:0]   rr [0:ROOT_BITS];
  logic [ROOT_BITS-1:0]   rq [0:ROOT_BITS];
  logic [RS_BITS-1:0]     rs [0:ROOT_BITS];

  assign rv[0] = fv[MASS_PROD_BITS];
  assign rx[0] = (2*ROOT_BITS)'(f_done.sq);
  assign rr[0] = '0;
  assign rq[0] = '0;
  assign rs[0] = r_first;

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_root
    pgf_sqrt_cell #(
      .ROOT_BITS(ROOT_BITS),
      .SIDE_BITS(RS_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (rv[i]),
      .rad_in   (rx[i]),
      .rem_in   (rr[i]),
      .root_in  (rq[i]),
      .side_in  (rs[i]),
      .valid_out(rv[i+1]),
      .rad_out  (rx[i+1]),
      .rem_out  (rr[i+1]),
      .root_out (rq[i+1]),
      .side_out (rs[i+1])
    );
  end

  // ----------------------------------------- product stage: F*|dx|, F*|dy|
  root_side_t r_done;
  assign r_done = root_side_t'(rs[ROOT_BITS]);

  logic                 p_valid;
  logic [PROD_BITS-1:0] p_x;
  logic [PROD_BITS-1:0] p_y;
  logic [ROOT_BITS-1:0] p_len;
  logic                 p_ny;
  xdiv_side_t           p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= rv[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    p_x          <= r_done.f * r_done.ax;
    p_y          <= r_done.f * r_done.ay;
    p_len        <= rq[ROOT_BITS];
    p_ny         <= r_done.ny;
    p_side.nx    <= r_done.nx;
    p_side.coinc <= r_done.coinc;
    p_side.mzero <= r_done.mzero;
    p_side.inf   <= r_done.inf;
    p_side.axz   <= (r_done.ax == '0);
    p_side.ayz   <= (r_done.ay == '0);
  end

  // ------------------------------- component divider rows: product / length
  logic                 xv [0:PROD_BITS];
  logic [PROD_BITS-1:0] xn [0:PROD_BITS];
  logic [ROOT_BITS-1:0] xr [0:PROD_BITS];
  logic [ROOT_BITS-1:0] xd [0:PROD_BITS];
  logic [XS_BITS-1:0]   xs [0:PROD_BITS];
  logic                 yv [0:PROD_BITS];
  logic [PROD_BITS-1:0] yn [0:PROD_BITS];
  logic [ROOT_BITS-1:0] yr [0:PROD_BITS];
  logic [ROOT_BITS-1:0] yd [0:PROD_BITS];
  logic                 ys [0:PROD_BITS];

  assign xv[0] = p_valid;
  assign xn[0] = p_x;
  assign xr[0] = '0;
  assign xd[0] = p_len;
  assign xs[0] = p_side;
  assign yv[0] = p_valid;
  assign yn[0] = p_y;
  assign yr[0] = '0;
  assign yd[0] = p_len;
  assign ys[0] = p_ny;

  for (genvar i = 0; i < PROD_BITS; i++) begin : g_comp
    pgf_div_cell #(
      .NUM_BITS (PROD_BITS),
      .DEN_BITS (ROOT_BITS),
      .SIDE_BITS(XS_BITS)
    ) u_xcell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (xv[i]),
      .num_in   (xn[i]),
      .rem_in   (xr[i]),
      .den_in   (xd[i]),
      .side_in  (xs[i]),
      .valid_out(xv[i+1]),
      .num_out  (xn[i+1]),
      .rem_out  (xr[i+1]),
      .den_out  (xd[i+1]),
      .side_out (xs[i+1])
    );

    pgf_div_cell #(
      .NUM_BITS (PROD_BITS),
      .DEN_BITS (ROOT_BITS),
      .SIDE_BITS(1)
    ) u_ycell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (yv[i]),
      .num_in   (yn[i]),
      .rem_in   (yr[i]),
      .den_in   (yd[i]),
      .side_in  (ys[i]),
      .valid_out(yv[i+1]),
      .num_out  (yn[i+1]),
      .rem_out  (yr[i+1]),
      .den_out  (yd[i+1]),
      .side_out (ys[i+1])
    );
  end

  // ------------------------------------------- output stage: saturate, hold
  xdiv_side_t x_done;
  comp_t      comp_x;
  comp_t      comp_y;

  assign x_done = xdiv_side_t'(xs[PROD_BITS]);
  assign comp_x = make_comp(xn[PROD_BITS], x_done.nx, x_done.axz, x_done.inf,
                            x_done.mzero);
  assign comp_y = make_comp(yn[PROD_BITS], ys[PROD_BITS], x_done.ayz, x_done.inf,
                            x_done.mzero);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= xv[PROD_BITS] && yv[PROD_BITS];
    end
  end

  // coincident bodies drop to zero force with the flag raised
  always_ff @(posedge clk) begin
    if (x_done.coinc) begin
      result.force_x    <= '0;
      result.force_y    <= '0;
      result.saturated  <= 1'b0;
      result.coincident <= 1'b1;
    end else begin
      result.force_x    <= comp_x.value;
      result.force_y    <= comp_y.value;
      result.saturated  <= comp_x.sat || comp_y.sat;
      result.coincident <= 1'b0;
    end
  end

`ifndef SYNTH
  // both component rows carry the same transfers in lock step
  a_rows_aligned: assert property (@(posedge clk) disable iff (rst)
    xv[PROD_BITS] == yv[PROD_BITS])
    else $error("component divider rows out of step");

  a_coinc_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.coincident |->
      result.force_x == '0 && result.force_y == '0 && !result.saturated)
    else $error("coincident result carries force");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    done && result.saturated |->
      result.force_x == POS_MAX[FORCE_BITS-1:0] ||
      result.force_x == NEG_MAX[FORCE_BITS-1:0] ||
      result.force_y == POS_MAX[FORCE_BITS-1:0] ||
      result.force_y == NEG_MAX[FORCE_BITS-1:0])
    else $error("saturation flag without a clipped component");
`endif

endmodule
